[sv/masked_byte_pattern_scan_assert.svh]
// ---------------------------------------------------------------------------
// masked_byte_pattern_scan assertion macros
// shared property forms for the scan block checks
// ---------------------------------------------------------------------------
`ifndef MASKED_BYTE_PATTERN_SCAN_ASSERT_SVH
`define MASKED_BYTE_PATTERN_SCAN_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define MBPS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("masked_byte_pattern_scan same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define MBPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("masked_byte_pattern_scan next-cycle check failed");

`endif

[sv/mbps_pkg.sv]
// ---------------------------------------------------------------------------
// mbps_pkg
// types and constants of the masked byte pattern scan
// ---------------------------------------------------------------------------
package mbps_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LEN_W       = 5;
    localparam int CNT_W       = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_IDX_W-1:0] REG_LEN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLO  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BHI  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MASK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE = 3'd4;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_item_t;

    typedef struct packed {
        logic             found;
        logic [CNT_W-1:0] first_offset;
        logic [CNT_W-1:0] match_count;
    } result_item_t;

    typedef struct packed {
        logic [LEN_W-1:0] pattern_length;
        logic [63:0]      pattern_bytes_low;
        logic [63:0]      pattern_bytes_high;
        logic [15:0]      care_mask;
        logic [CNT_W-1:0] section_base;
    } cfg_t;

    typedef logic [MAX_PATTERN-1:0][7:0] window_t;

endpackage

[sv/mbps_match.sv]
// ---------------------------------------------------------------------------
// mbps_match
// masked compare of the newest window against the configured pattern
// ---------------------------------------------------------------------------
module mbps_match
(
    input  mbps_pkg::cfg_t                  cfg,
    input  mbps_pkg::window_t               window,
    input  logic [mbps_pkg::CNT_W-1:0]      seen,
    output logic                            hit
);

    logic [mbps_pkg::LEN_W-1:0]                     len;
    logic                                           len_ok;
    logic                                           enough;
    logic [127:0]                                   pattern;
    logic [mbps_pkg::MAX_PATTERN-1:0][mbps_pkg::LEN_W-1:0] pos;
    logic [mbps_pkg::MAX_PATTERN-1:0]               mismatch;

    assign len     = cfg.pattern_length;
    assign len_ok  = (len != '0) &&
                     (len <= mbps_pkg::LEN_W'(mbps_pkg::MAX_PATTERN));
    assign enough  = seen >= {{(mbps_pkg::CNT_W - mbps_pkg::LEN_W){1'b0}}, len};
    assign pattern = {cfg.pattern_bytes_high, cfg.pattern_bytes_low};

    // pattern byte i lines up with window entry len-1-i
    always_comb
    begin
        for (int i = 0; i < mbps_pkg::MAX_PATTERN; i++)
        begin
            pos[i]      = len - mbps_pkg::LEN_W'(1) - mbps_pkg::LEN_W'(i);
            mismatch[i] = (mbps_pkg::LEN_W'(i) < len) && cfg.care_mask[i] &&
                          (window[pos[i][mbps_pkg::IDX_W-1:0]] != pattern[8*i +: 8]);
        end
    end

    assign hit = len_ok && enough && !(|mismatch);

endmodule

[sv/masked_byte_pattern_scan.sv]
// ---------------------------------------------------------------------------
// masked_byte_pattern_scan
// streams section bytes, counts masked pattern matches, reports on last byte
// ---------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  byte     | in        | byte_valid/stall     | byte_item (data_byte, last_byte)
//  result   | out       | result_valid/stall   | result_item (found, first_offset,
//           |           |                      |   match_count)
//  cfg      | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
//  one byte per cycle while byte_stall is low; a byte goes through an input
//  register and a single compare/update stage; the result is registered from the last byte
//  reset clears configuration, scan state and both valid flags at once
//  byte_stall rises only while a buffered last byte waits on a stalled result
//  cfg_ready is always high
// ---------------------------------------------------------------------------
module masked_byte_pattern_scan
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                byte_valid,
    output logic                                byte_stall,
    input  mbps_pkg::byte_item_t                byte_item,

    output logic                                result_valid,
    input  logic                                result_stall,
    output mbps_pkg::result_item_t              result_item,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mbps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]     cfg_data
);

    `include "masked_byte_pattern_scan_assert.svh"

    mbps_pkg::cfg_t                 cfg_reg;
    logic                           stage_valid_reg;
    logic                           stage_valid_next;
    mbps_pkg::byte_item_t           stage_item_reg;
    mbps_pkg::window_t              window_reg;
    mbps_pkg::window_t              window_next;
    logic [mbps_pkg::CNT_W-1:0]     seen_reg;
    logic [mbps_pkg::CNT_W-1:0]     seen_next;
    logic [mbps_pkg::CNT_W-1:0]     hits_reg;
    logic [mbps_pkg::CNT_W-1:0]     hits_next;
    logic [mbps_pkg::CNT_W-1:0]     earliest_reg;
    logic [mbps_pkg::CNT_W-1:0]     earliest_next;
    logic                           any_hit_reg;
    logic                           any_hit_next;
    logic                           result_valid_reg;
    logic                           result_valid_next;
    mbps_pkg::result_item_t         result_item_reg;
    mbps_pkg::result_item_t         result_item_next;

    logic                           blocked;
    logic                           take;
    logic                           process;
    logic                           hit;
    logic                           cfg_write;

    // handshakes
    assign blocked    = stage_valid_reg && stage_item_reg.last_byte &&
                        result_valid_reg && result_stall;
    assign byte_stall = blocked;
    assign take       = byte_valid && !blocked;
    assign process    = stage_valid_reg && !blocked;
    assign cfg_ready  = 1'b1;
    assign cfg_write  = cfg_valid && cfg_ready;

    assign stage_valid_next = blocked || byte_valid;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                mbps_pkg::REG_LEN:
                    cfg_reg.pattern_length <= cfg_data[mbps_pkg::LEN_W-1:0];
                mbps_pkg::REG_BLO:
                    cfg_reg.pattern_bytes_low <= cfg_data;
                mbps_pkg::REG_BHI:
                    cfg_reg.pattern_bytes_high <= cfg_data;
                mbps_pkg::REG_MASK:
                    cfg_reg.care_mask <= cfg_data[15:0];
                mbps_pkg::REG_BASE:
                    cfg_reg.section_base <= cfg_data[mbps_pkg::CNT_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // window shift and byte count
    always_comb
    begin
        window_next[0] = stage_item_reg.data_byte;
        for (int k = 1; k < mbps_pkg::MAX_PATTERN; k++)
        begin
            window_next[k] = window_reg[k-1];
        end
        seen_next = (seen_reg == mbps_pkg::CNT_MAX) ? seen_reg
                                                    : seen_reg + mbps_pkg::CNT_W'(1);
    end

    mbps_match u_match
    (
        .cfg    (cfg_reg),
        .window (window_next),
        .seen   (seen_next),
        .hit    (hit)
    );

    // match bookkeeping and result
    always_comb
    begin
        any_hit_next  = any_hit_reg || hit;
        earliest_next = earliest_reg;
        if (hit && !any_hit_reg)
        begin
            earliest_next = cfg_reg.section_base + seen_next -
                            {{(mbps_pkg::CNT_W - mbps_pkg::LEN_W){1'b0}},
                             cfg_reg.pattern_length};
        end
        hits_next = (hit && (hits_reg != mbps_pkg::CNT_MAX))
                    ? hits_reg + mbps_pkg::CNT_W'(1) : hits_reg;

        result_item_next.found        = any_hit_next;
        result_item_next.first_offset = any_hit_next ? earliest_next : '0;
        result_item_next.match_count  = hits_next;

        result_valid_next = (process && stage_item_reg.last_byte) ||
                            (result_valid_reg && result_stall);
    end

    // control and scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
            window_reg       <= '0;
            seen_reg         <= '0;
            hits_reg         <= '0;
            earliest_reg     <= '0;
            any_hit_reg      <= 1'b0;
        end
        else
        begin
            stage_valid_reg  <= stage_valid_next;
            result_valid_reg <= result_valid_next;
            if (process)
            begin
                if (stage_item_reg.last_byte)
                begin
                    window_reg   <= '0;
                    seen_reg     <= '0;
                    hits_reg     <= '0;
                    earliest_reg <= '0;
                    any_hit_reg  <= 1'b0;
                end
                else
                begin
                    window_reg   <= window_next;
                    seen_reg     <= seen_next;
                    hits_reg     <= hits_next;
                    earliest_reg <= earliest_next;
                    any_hit_reg  <= any_hit_next;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_item_reg <= byte_item;
        end
        if (process && stage_item_reg.last_byte)
        begin
            result_item_reg <= result_item_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_item  = result_item_reg;

    // checks
    `MBPS_ASSERT_SAME(a_stall_cause, byte_stall, stage_valid_reg && stage_item_reg.last_byte && result_valid_reg)
    `MBPS_ASSERT_SAME(a_no_hit_offset, result_valid && !result_item.found, result_item.first_offset == '0)
    `MBPS_ASSERT_SAME(a_count_needs_hit, !any_hit_reg, hits_reg == '0 && earliest_reg == '0)
    `MBPS_ASSERT_NEXT(a_clear_after_last, process && stage_item_reg.last_byte, seen_reg == '0 && !any_hit_reg && result_valid)

endmodule
